// ===== rtl/core/rrf_pkg.sv =====
// Package: shared types, widths and float compare helpers for the row range filter.
`timescale 1ns / 1ps
package rrf_pkg;

  localparam int unsigned LimitSlots = 8;
  localparam int unsigned FloatW    = 32;
  localparam int unsigned SlotIdxW  = 3;
  localparam int unsigned ActiveW   = 4;
  localparam int unsigned OutRowW   = 40;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 4;

  localparam logic [CfgIdxW-1:0] CFG_OR_MODE       = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LIMITS = 1'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CELL = 1'b1;

  // Per-cell outcome gathered over all limit slots
  typedef struct packed {
    logic all_fail;   // some defined side failed
    logic any_pass;   // some matching slot held on every defined side
    logic free_pass;  // some slot in use has both sides unlimited
  } slot_hits_t;

  function automatic logic fp_is_nan(input logic [FloatW-1:0] a);
    fp_is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  // Map to an unsigned key that orders like the float value
  function automatic logic [FloatW-1:0] fp_key(input logic [FloatW-1:0] a);
    fp_key = a[31] ? ~a : (a | 32'h8000_0000);
  endfunction

  // a < b with C semantics: false when either is NaN, +0 equals -0
  function automatic logic fp_lt(input logic [FloatW-1:0] a, input logic [FloatW-1:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    fp_lt = !fp_is_nan(a) && !fp_is_nan(b) && !both_zero && (fp_key(a) < fp_key(b));
  endfunction

endpackage

// ===== rtl/core/rrf_slot_bank.sv =====
// Limit slot storage and parallel comparison of one cell against every slot.
`timescale 1ns / 1ps
module rrf_slot_bank #(
  parameter int unsigned COLUMN_BITS = 8
) (
  input  logic                          clk,
  input  logic                          load_en,
  input  logic [rrf_pkg::SlotIdxW-1:0]  load_slot,
  input  logic [COLUMN_BITS-1:0]        load_column,
  input  logic [rrf_pkg::FloatW-1:0]    load_low,
  input  logic [rrf_pkg::FloatW-1:0]    load_high,
  input  logic                          load_low_free,
  input  logic                          load_high_free,
  input  logic [rrf_pkg::ActiveW-1:0]   active_limits,
  input  logic                          cell_en,
  input  logic [rrf_pkg::FloatW-1:0]    cell_value,
  input  logic [COLUMN_BITS-1:0]        cell_column,
  output rrf_pkg::slot_hits_t           hits
);

  logic [COLUMN_BITS-1:0]     col_r      [rrf_pkg::LimitSlots];
  logic [rrf_pkg::FloatW-1:0] low_r      [rrf_pkg::LimitSlots];
  logic [rrf_pkg::FloatW-1:0] high_r     [rrf_pkg::LimitSlots];
  logic [rrf_pkg::LimitSlots-1:0] low_free_r;
  logic [rrf_pkg::LimitSlots-1:0] high_free_r;

  logic [rrf_pkg::LimitSlots-1:0] in_use;
  logic [rrf_pkg::LimitSlots-1:0] fail_v;
  logic [rrf_pkg::LimitSlots-1:0] pass_v;
  logic [rrf_pkg::LimitSlots-1:0] free_v;

  always_ff @(posedge clk) begin
    for (int s = 0; s < rrf_pkg::LimitSlots; s++) begin
      if (load_en && (32'(load_slot) == s)) begin
        col_r[s]       <= load_column;
        low_r[s]       <= load_low;
        high_r[s]      <= load_high;
        low_free_r[s]  <= load_low_free;
        high_free_r[s] <= load_high_free;
      end
    end
  end

  genvar k;
  generate
    for (k = 0; k < rrf_pkg::LimitSlots; k++) begin : g_slot
      logic match;
      logic below;
      logic above;
      logic nan_cell;

      assign in_use[k] = 32'(active_limits) > k;
      assign match     = cell_en && in_use[k] && (col_r[k] == cell_column);
      assign nan_cell  = rrf_pkg::fp_is_nan(cell_value) || rrf_pkg::fp_is_nan(low_r[k]);
      assign below     = rrf_pkg::fp_lt(cell_value, low_r[k]);
      assign above     = rrf_pkg::fp_lt(high_r[k], cell_value);
      assign fail_v[k] = match && ((!low_free_r[k] && below) || (!high_free_r[k] && above));
      // v >= low and v <= high are false on any NaN operand
      assign pass_v[k] = match
                       && (low_free_r[k] || (!nan_cell && !below))
                       && (high_free_r[k] || (!rrf_pkg::fp_is_nan(cell_value)
                           && !rrf_pkg::fp_is_nan(high_r[k]) && !above));
      assign free_v[k] = in_use[k] && low_free_r[k] && high_free_r[k];
    end
  endgenerate

  assign hits.all_fail  = |fail_v;
  assign hits.any_pass  = |pass_v;
  assign hits.free_pass = |free_v;

endmodule

// ===== rtl/core/row_range_filter.sv =====
// Row range filter top level: input stage, limit bank, accumulators and result register.
`timescale 1ns / 1ps
// Takes one transaction per cycle: a limit load or one cell of a row. Each cell is
// registered, then compared combinationally against all limit slots, and on the last
// cell of a row the verdict and row number are written to the output register.
// The input keeps flowing while a result waits;
// it stalls only when a row end meets a still-occupied, stalled output register.
// Configuration writes are expected only while the block is idle.
module row_range_filter #(
  parameter int unsigned COLUMN_BITS = 8,
  parameter int unsigned ROW_BITS    = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rrf_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [rrf_pkg::SlotIdxW-1:0]  in_limit_slot,
  input  logic [COLUMN_BITS-1:0]        in_limit_column,
  input  logic [rrf_pkg::FloatW-1:0]    in_limit_low,
  input  logic [rrf_pkg::FloatW-1:0]    in_limit_high,
  input  logic                          in_low_unlimited,
  input  logic                          in_high_unlimited,
  input  logic [rrf_pkg::FloatW-1:0]    in_cell_value,
  input  logic [COLUMN_BITS-1:0]        in_cell_column,
  input  logic                          in_row_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_row_selected,
  output logic [rrf_pkg::OutRowW-1:0]   out_row_number
);

  logic                          or_mode_r;
  logic [rrf_pkg::ActiveW-1:0]   active_r;

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_action_r;
  logic [rrf_pkg::SlotIdxW-1:0]  s1_slot_r;
  logic [COLUMN_BITS-1:0]        s1_lcol_r;
  logic [rrf_pkg::FloatW-1:0]    s1_low_r;
  logic [rrf_pkg::FloatW-1:0]    s1_high_r;
  logic                          s1_lfree_r;
  logic                          s1_hfree_r;
  logic [rrf_pkg::FloatW-1:0]    s1_value_r;
  logic [COLUMN_BITS-1:0]        s1_ccol_r;
  logic                          s1_row_end_r;

  logic                          all_r, all_nxt;
  logic                          any_r, any_nxt;
  logic [ROW_BITS-1:0]           row_cnt_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_sel_r;
  logic [rrf_pkg::OutRowW-1:0]   out_row_r;

  logic                          in_accept;
  logic                          s1_row_out;
  logic                          s1_fire;
  rrf_pkg::slot_hits_t           hits;

  assign s1_row_out = s1_action_r == rrf_pkg::ACT_CELL && s1_row_end_r;
  assign s1_fire    = s1_valid_r && !(s1_row_out && out_valid_r && out_stall);
  assign in_stall   = s1_valid_r && !s1_fire;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      or_mode_r <= 1'b0;
      active_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rrf_pkg::CFG_OR_MODE:       or_mode_r <= cfg_wdata[0];
        rrf_pkg::CFG_ACTIVE_LIMITS: active_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r  <= in_action;
      s1_slot_r    <= in_limit_slot;
      s1_lcol_r    <= in_limit_column;
      s1_low_r     <= in_limit_low;
      s1_high_r    <= in_limit_high;
      s1_lfree_r   <= in_low_unlimited;
      s1_hfree_r   <= in_high_unlimited;
      s1_value_r   <= in_cell_value;
      s1_ccol_r    <= in_cell_column;
      s1_row_end_r <= in_row_end;
    end
  end

  rrf_slot_bank #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_bank (
    .clk            (clk),
    .load_en        (s1_fire && s1_action_r == rrf_pkg::ACT_LOAD),
    .load_slot      (s1_slot_r),
    .load_column    (s1_lcol_r),
    .load_low       (s1_low_r),
    .load_high      (s1_high_r),
    .load_low_free  (s1_lfree_r),
    .load_high_free (s1_hfree_r),
    .active_limits  (active_r),
    .cell_en        (s1_fire && s1_action_r == rrf_pkg::ACT_CELL),
    .cell_value     (s1_value_r),
    .cell_column    (s1_ccol_r),
    .hits           (hits)
  );

  assign all_nxt = all_r && !hits.all_fail;
  assign any_nxt = any_r || hits.any_pass;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_row_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_r       <= 1'b1;
      any_r       <= 1'b0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire && s1_action_r == rrf_pkg::ACT_CELL) begin
        if (s1_row_end_r) begin
          // restart the accumulators for the next row
          all_r     <= 1'b1;
          any_r     <= 1'b0;
          row_cnt_r <= row_cnt_r + ROW_BITS'(1);
        end else begin
          all_r <= all_nxt;
          any_r <= any_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_row_out) begin
      out_sel_r <= or_mode_r ? (any_nxt || hits.free_pass) : all_nxt;
      out_row_r <= rrf_pkg::OutRowW'(64'(row_cnt_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_selected = out_sel_r;
  assign out_row_number   = out_row_r;

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s1_row_out))
    else $error("input stalled without a waiting result");

  a_row_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_row_out) |=> out_valid_r)
    else $error("row end did not produce a result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_row_r)))
    else $error("stalled result lost or changed");

  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_row_out) |=> (row_cnt_r == $past(row_cnt_r) + ROW_BITS'(1)))
    else $error("row counter did not advance");

endmodule

// ===== test/row_range_filter_checker.sv =====
// Checker for the row range filter: tracks limits and config, predicts row verdicts, compares.
`timescale 1ns / 1ps
module row_range_filter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rrf_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_action,
  input  logic [rrf_pkg::SlotIdxW-1:0]  in_limit_slot,
  input  logic [7:0]                    in_limit_column,
  input  logic [31:0]                   in_limit_low,
  input  logic [31:0]                   in_limit_high,
  input  logic                          in_low_unlimited,
  input  logic                          in_high_unlimited,
  input  logic [31:0]                   in_cell_value,
  input  logic [7:0]                    in_cell_column,
  input  logic                          in_row_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_row_selected,
  input  logic [rrf_pkg::OutRowW-1:0]   out_row_number,
  output int                            fail_count,
  output int                            verdicts_pending,
  output int                            rows_checked
);

  typedef struct {
    logic [7:0]  column;
    logic [31:0] low;
    logic [31:0] high;
    logic        low_free;
    logic        high_free;
  } limit_t;

  typedef struct {
    logic                         selected;
    logic [rrf_pkg::OutRowW-1:0]  row;
  } verdict_t;

  limit_t             limits [8];
  verdict_t           verdict_q [$];
  logic               all_hold;
  logic               any_hold;
  logic [39:0]        row_count;
  logic               or_mode;
  logic [3:0]         active_limits;

  function automatic bit is_nan(logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 0);
  endfunction

  // C float a < b on bit patterns: sign-magnitude ordering, signed zeros equal
  function automatic bit flt_less(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 0;
    if (a[30:0] == 0 && b[30:0] == 0) return 0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic bit flt_le(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && !flt_less(b, a);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_cell(logic [31:0] v, logic [7:0] col, logic last);
    int n;
    verdict_t vd;
    n = (active_limits > 8) ? 8 : active_limits;
    for (int k = 0; k < n; k++) begin
      if (limits[k].column == col) begin
        if (!limits[k].low_free && flt_less(v, limits[k].low)) all_hold = 0;
        if (!limits[k].high_free && flt_less(limits[k].high, v)) all_hold = 0;
        if ((limits[k].low_free || flt_le(limits[k].low, v)) &&
            (limits[k].high_free || flt_le(v, limits[k].high)))
          any_hold = 1;
      end
    end
    if (last) begin
      if (or_mode) begin
        vd.selected = any_hold;
        for (int k = 0; k < n; k++)
          if (limits[k].low_free && limits[k].high_free) vd.selected = 1;
      end else begin
        vd.selected = all_hold;
      end
      vd.row = row_count;
      verdict_q = {verdict_q, vd};
      row_count++;
      all_hold = 1;
      any_hold = 0;
    end
  endtask

  always @(posedge clk) begin
    verdict_t vd;
    if (!rst_n) begin
      verdict_q.delete();
      all_hold      = 1;
      any_hold      = 0;
      row_count     = 0;
      or_mode       = 0;
      active_limits = 0;
      fail_count    = 0;
      rows_checked  = 0;
    end else begin
      // compare first: a result is never produced in the cycle its row ends
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected row result", 64'(out_row_number), 64'(0));
        end else begin
          vd = verdict_q.pop_front();
          if (out_row_selected !== vd.selected)
            report_mismatch("row_selected", 64'(out_row_selected), 64'(vd.selected));
          if (out_row_number !== vd.row)
            report_mismatch("row_number", 64'(out_row_number), 64'(vd.row));
          rows_checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == rrf_pkg::CFG_OR_MODE) or_mode = cfg_wdata[0];
        else if (cfg_index == rrf_pkg::CFG_ACTIVE_LIMITS) active_limits = cfg_wdata[3:0];
      end
      if (in_valid && !in_stall) begin
        if (in_action == rrf_pkg::ACT_LOAD) begin
          limits[in_limit_slot].column    = in_limit_column;
          limits[in_limit_slot].low       = in_limit_low;
          limits[in_limit_slot].high      = in_limit_high;
          limits[in_limit_slot].low_free  = in_low_unlimited;
          limits[in_limit_slot].high_free = in_high_unlimited;
        end else begin
          predict_cell(in_cell_value, in_cell_column, in_row_end);
        end
      end
    end
    verdicts_pending <= verdict_q.size();
  end

endmodule

// ===== test/row_range_filter_tb.sv =====
// Testbench top for the row range filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module row_range_filter_tb;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rrf_pkg::CfgIdxW-1:0]   cfg_index;
  logic [rrf_pkg::CfgDataW-1:0]  cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [rrf_pkg::SlotIdxW-1:0]  in_limit_slot;
  logic [7:0]                    in_limit_column;
  logic [31:0]                   in_limit_low;
  logic [31:0]                   in_limit_high;
  logic                          in_low_unlimited;
  logic                          in_high_unlimited;
  logic [31:0]                   in_cell_value;
  logic [7:0]                    in_cell_column;
  logic                          in_row_end;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_row_selected;
  logic [rrf_pkg::OutRowW-1:0]   out_row_number;

  int fail_count;
  int verdicts_pending;
  int rows_checked;
  int gap_pct;
  int stall_pct;
  int cycles = 0;
  int items_sent;
  int cfg_writes;

  localparam int CycleLimit = 400000;

  row_range_filter dut (.*);

  row_range_filter_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("row_range_filter_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_float();
    logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                   32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff,
                                   32'h3f80_0000, 32'h4000_0000, 32'hbf80_0000,
                                   32'h0000_0001};
    case ($urandom_range(9))
      0: return $urandom;
      1, 2: return specials[$urandom_range(9)];
      // values around 0.5 .. 4 so cells land on both sides of the bounds
      default: return {1'($urandom_range(9) == 0), 8'd126 + 8'($urandom_range(2)),
                       23'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] pick_col();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
  endfunction

  task automatic send(logic act, logic [2:0] slot, logic [7:0] lcol, logic [31:0] lo,
                      logic [31:0] hi, logic lf, logic hf, logic [31:0] v,
                      logic [7:0] ccol, logic last);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid          <= 1;
    in_action         <= act;
    in_limit_slot     <= slot;
    in_limit_column   <= lcol;
    in_limit_low      <= lo;
    in_limit_high     <= hi;
    in_low_unlimited  <= lf;
    in_high_unlimited <= hf;
    in_cell_value     <= v;
    in_cell_column    <= ccol;
    in_row_end        <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_limit(logic [2:0] slot, logic [7:0] col, logic [31:0] lo,
                            logic [31:0] hi, logic lf, logic hf);
    send(rrf_pkg::ACT_LOAD, slot, col, lo, hi, lf, hf, $urandom, 8'($urandom),
         1'($urandom));
  endtask

  task automatic send_cell(logic [31:0] v, logic [7:0] col, logic last);
    send(rrf_pkg::ACT_CELL, 3'($urandom), 8'($urandom), $urandom, $urandom, 1'($urandom),
         1'($urandom), v, col, last);
  endtask

  // hold the sender until every verdict is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [rrf_pkg::CfgIdxW-1:0] idx,
                           logic [rrf_pkg::CfgDataW-1:0] data);
    drain();
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 0;
    cfg_writes++;
  endtask

  task automatic random_row();
    int len;
    len = $urandom_range(1, 6);
    for (int c = 0; c < len; c++) send_cell(pick_float(), pick_col(), c == len - 1);
  endtask

  task automatic random_load();
    int r;
    r = $urandom_range(3);
    load_limit(3'($urandom), pick_col(), pick_float(), pick_float(),
               r == 1 || r == 3, r == 2 || r == 3);
  endtask

  initial begin
    items_sent = 0;  cfg_writes = 0;
    gap_pct = 11;  stall_pct = 76;
    rst_n = 0;  cfg_we = 0;  cfg_index = '0;  cfg_wdata = '0;
    in_valid = 0;  in_action = 0;  in_limit_slot = 0;  in_limit_column = 0;
    in_limit_low = 0;  in_limit_high = 0;  in_low_unlimited = 0;  in_high_unlimited = 0;
    in_cell_value = 0;  in_cell_column = 0;  in_row_end = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // no limits in use: AND takes the row, OR drops it
    send_cell(32'h3f80_0000, 8'd0, 1'b1);
    write_cfg(rrf_pkg::CFG_OR_MODE, 4'd1);
    send_cell(32'h3f80_0000, 8'd0, 1'b1);

    // fill every slot before any is put in use
    load_limit(3'd0, 8'd0, 32'h3f80_0000, 32'h4000_0000, 1'b0, 1'b0);
    load_limit(3'd1, 8'd1, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b0);
    load_limit(3'd2, 8'd2, 32'h0, 32'h0, 1'b1, 1'b1);
    load_limit(3'd3, 8'd255, 32'h8000_0000, 32'h7f80_0000, 1'b0, 1'b0);
    load_limit(3'd4, 8'd0, 32'h7fc0_0000, 32'h4040_0000, 1'b0, 1'b1);
    load_limit(3'd5, 8'd1, 32'hff80_0000, 32'h0000_0001, 1'b0, 1'b0);
    load_limit(3'd6, 8'd3, 32'h4000_0000, 32'h3f80_0000, 1'b0, 1'b0);
    load_limit(3'd7, 8'd0, 32'hbf80_0000, 32'h7fff_ffff, 1'b0, 1'b1);

    write_cfg(rrf_pkg::CFG_ACTIVE_LIMITS, 4'd15);   // saturates at the slot count
    send_cell(32'h7fc0_0000, 8'd0, 1'b0);           // NaN cell
    send_cell(32'h0000_0000, 8'd1, 1'b0);           // +0 against a -0 bound
    send_cell(32'h3f80_0000, 8'd0, 1'b1);           // repeated column
    send_cell(32'hffff_ffff, 8'd255, 1'b1);
    write_cfg(rrf_pkg::CFG_OR_MODE, 4'd0);
    send_cell(32'h7fc0_0000, 8'd0, 1'b1);
    send_cell(32'h8000_0000, 8'd255, 1'b0);
    send_cell(32'h3fc0_0000, 8'd9, 1'b1);           // absent columns
    write_cfg(rrf_pkg::CFG_ACTIVE_LIMITS, 4'd2);
    send_cell(32'h3fc0_0000, 8'd0, 1'b0);
    write_cfg(rrf_pkg::CFG_OR_MODE, 4'd1);          // mode flips inside a row
    send_cell(32'h4100_0000, 8'd1, 1'b1);
    write_cfg(rrf_pkg::CFG_ACTIVE_LIMITS, 4'd8);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 76 : 0;
      stall_pct = (phase == 0) ? 76 : (phase == 1) ? 11 : 0;
      for (int setting = 0; setting < 3; setting++) begin
        write_cfg(rrf_pkg::CFG_OR_MODE, 4'($urandom_range(1)));
        write_cfg(rrf_pkg::CFG_ACTIVE_LIMITS,
                  (setting == 0) ? 4'd0 : (setting == 1) ? 4'd8 : 4'($urandom_range(15)));
        for (int n = 0; n < 30; n++) begin
          if ($urandom_range(99) < 15) random_load();
          else random_row();
        end
      end
    end

    drain();
    while (verdicts_pending != 0 && cycles < CycleLimit) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d transactions, %0d row verdicts, %0d register writes",
             items_sent, rows_checked, cfg_writes);
    $display("both combine modes, zero to saturated slot counts, NaN and signed-zero cells");
    if (fail_count == 0 && verdicts_pending == 0)
      $display("row_range_filter_tb: PASS");
    else
      $display("row_range_filter_tb: FAIL");
    $finish;
  end
endmodule
